>>> rtl/efms_pkg.sv
// Shared widths and constants for the earliest-free-machine scheduler.
`timescale 1ns / 1ps

package efms_pkg;

    localparam int MACHINES  = 16;
    localparam int TIME_W    = 32;
    localparam int DUR_W     = 16;
    localparam int MIDX_W    = 4;
    localparam int ACT_W     = 5;

    localparam logic [ACT_W-1:0]  ACTIVE_RESET = 5'd16;
    localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [DUR_W-1:0]  t_dur;
    typedef logic [MIDX_W-1:0] t_midx;
    typedef logic [ACT_W-1:0]  t_active;

endpackage

>>> rtl/efms_job_if.sv
// Job channel: valid/ready handshake with duration and batch-start flag.
`timescale 1ns / 1ps

interface efms_job_if;
    logic          valid;
    logic          ready;
    efms_pkg::t_dur job_duration;
    logic          new_batch;

    modport source (output valid, output job_duration, output new_batch, input ready);
    modport sink   (input valid, input job_duration, input new_batch, output ready);
endinterface

>>> rtl/efms_res_if.sv
// Result channel: valid/ready handshake with completion time, makespan and machine.
`timescale 1ns / 1ps

interface efms_res_if;
    logic            valid;
    logic            ready;
    efms_pkg::t_time completion_time;
    efms_pkg::t_time makespan;
    efms_pkg::t_midx machine_index;

    modport source (output valid, output completion_time, output makespan,
                    output machine_index, input ready);
    modport sink   (input valid, input completion_time, input makespan,
                    input machine_index, output ready);
endinterface

>>> rtl/efms_min_tree.sv
// Compare tree that finds the earliest free time among enabled machines.
`timescale 1ns / 1ps

module efms_min_tree #(
    parameter int N     = efms_pkg::MACHINES,
    parameter int IDX_W = (N > 1) ? $clog2(N) : 1
) (
    input  efms_pkg::t_time    i_times [N],
    input  logic [N-1:0]       i_enable,
    output efms_pkg::t_time    o_min_time,
    output logic [IDX_W-1:0]   o_min_idx
);

    localparam int LEAVES = 2 ** IDX_W;
    localparam int NODES  = 2 * LEAVES - 1;
    localparam int KEY_W  = efms_pkg::TIME_W + 1;

    // key MSB set marks a disabled or padding leaf, so it always loses
    logic [KEY_W-1:0] key [NODES];
    logic [IDX_W-1:0] idx [NODES];

    always_comb begin
        for (int j = 0; j < LEAVES; j++) begin
            if (j < N) begin
                key[LEAVES-1+j] = {~i_enable[j], i_times[j]};
            end else begin
                key[LEAVES-1+j] = {1'b1, efms_pkg::TIME_MAX};
            end
            idx[LEAVES-1+j] = IDX_W'(j);
        end
        // left child holds lower indices: take right only when strictly smaller
        for (int n = LEAVES - 2; n >= 0; n--) begin
            if (key[2*n+2] < key[2*n+1]) begin
                key[n] = key[2*n+2];
                idx[n] = idx[2*n+2];
            end else begin
                key[n] = key[2*n+1];
                idx[n] = idx[2*n+1];
            end
        end
    end

    assign o_min_time = key[0][efms_pkg::TIME_W-1:0];
    assign o_min_idx  = idx[0];

endmodule

>>> rtl/earliest_free_machine_scheduler.sv
// Top level of the earliest-free-machine list scheduler.
`timescale 1ns / 1ps

// Assigns each job to the enabled machine with the earliest free time (lowest
// index on ties) and returns its saturating completion time, the batch makespan
// and the chosen machine. One job is taken per cycle, back to back, while
// results are accepted: a job sits in an input register, then a compare tree
// over the machine free times plus one 32-bit saturating add produce the result
// register and update the chosen machine's free time at the same edge, so the
// next job sees the updated state. While a finished result waits, one more job
// can be taken into an empty input register, where it is held until the result
// is accepted. active_machines (0 acts as 1, values above MACHINES act as
// MACHINES) may be written only while the block is idle.
module earliest_free_machine_scheduler #(
    parameter int MACHINES = efms_pkg::MACHINES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  efms_pkg::t_active       i_cfg_wdata,
    efms_job_if.sink                i_job,
    efms_res_if.source              o_res
);

    localparam int IDX_W = (MACHINES > 1) ? $clog2(MACHINES) : 1;

    logic              r_in_valid;
    efms_pkg::t_dur    r_in_dur;
    logic              r_in_batch;
    logic              r_out_valid;
    efms_pkg::t_time   r_out_done;
    efms_pkg::t_time   r_out_span;
    efms_pkg::t_midx   r_out_midx;
    efms_pkg::t_active r_active;
    efms_pkg::t_time   r_free [MACHINES];
    efms_pkg::t_time   r_makespan;

    efms_pkg::t_time   n_free [MACHINES];
    efms_pkg::t_time   n_makespan;
    efms_pkg::t_time   eff_times [MACHINES];
    logic [MACHINES-1:0] enable;
    efms_pkg::t_time   min_time;
    logic [IDX_W-1:0]  min_idx;
    logic [IDX_W+3:0]  min_idx_ext;
    logic [efms_pkg::TIME_W:0] sum;
    efms_pkg::t_time   done;
    efms_pkg::t_time   span_base;
    logic              advance;
    logic              take;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_job.ready = !r_in_valid || advance;
    assign take        = i_job.valid && i_job.ready;

    // a new batch sees every machine as free at time zero
    always_comb begin
        for (int i = 0; i < MACHINES; i++) begin
            eff_times[i] = r_in_batch ? '0 : r_free[i];
            enable[i]    = (i == 0) || (32'(i) < 32'(r_active));
        end
    end

    efms_min_tree #(
        .N     (MACHINES),
        .IDX_W (IDX_W)
    ) u_min_tree (
        .i_times    (eff_times),
        .i_enable   (enable),
        .o_min_time (min_time),
        .o_min_idx  (min_idx)
    );

    assign sum         = {1'b0, min_time} + (efms_pkg::TIME_W + 1)'(r_in_dur);
    assign done        = sum[efms_pkg::TIME_W] ? efms_pkg::TIME_MAX
                                               : sum[efms_pkg::TIME_W-1:0];
    assign span_base   = r_in_batch ? '0 : r_makespan;
    assign n_makespan  = (done > span_base) ? done : span_base;
    assign min_idx_ext = {4'b0, min_idx};

    always_comb begin
        for (int i = 0; i < MACHINES; i++) begin
            if (IDX_W'(i) == min_idx) begin
                n_free[i] = done;
            end else begin
                n_free[i] = eff_times[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= efms_pkg::ACTIVE_RESET;
            r_makespan  <= '0;
            for (int i = 0; i < MACHINES; i++) begin
                r_free[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_makespan  <= n_makespan;
                for (int i = 0; i < MACHINES; i++) begin
                    r_free[i] <= n_free[i];
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: hold until the next transfer
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_dur   <= i_job.job_duration;
            r_in_batch <= i_job.new_batch;
        end
        if (advance) begin
            r_out_done <= done;
            r_out_span <= n_makespan;
            r_out_midx <= min_idx_ext[3:0];
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.completion_time = r_out_done;
    assign o_res.makespan        = r_out_span;
    assign o_res.machine_index   = r_out_midx;

endmodule
